// ----- rtl/gtpu_tp_pkg.sv -----
// ----------------------------------------------------------------------------
// GTP-U telemetry parser package
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gtpu_tp_pkg;

    localparam int TABLE_ENTRIES   = 1024;
    localparam int TIDX_W          = $clog2(TABLE_ENTRIES);
    localparam int FILL_W          = TIDX_W + 1;
    localparam int MAX_FRAME_BYTES = 16384;
    localparam int POS_W           = 15;
    localparam int OUT_W           = 352;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [CFG_IDX_W-1:0] REG_TUNNEL_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STAT_SELECT = 1'b1;

    localparam logic [1:0] CLS_GTPU      = 2'd0;
    localparam logic [1:0] CLS_MALFORMED = 2'd1;
    localparam logic [1:0] CLS_NON_GTPU  = 2'd2;
    localparam logic [1:0] CLS_RUNT      = 2'd3;

    typedef enum logic [2:0] {
        ST_RECV,
        ST_CLASSIFY,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic byte_take;
        logic classify;
        logic scan_rd;
        logic scan_cmp;
        logic cnt_rd;
        logic cnt_wr;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic gtpu;
        logic empty;
        logic match;
        logic scan_last;
        logic full;
    } stat_t;

endpackage

// ----- rtl/gtpu_teid_telemetry_parser_unit.sv -----
// ----------------------------------------------------------------------------
// GTP-U TEID telemetry parser
// Parses Ethernet/IPv4/UDP/GTP-U headers and keeps per-TEID and global stats.
// ----------------------------------------------------------------------------
// Every non-final byte is accepted as soon as it is offered. After the final
// byte a frame that is not GTP-U is classified and loaded to the output; a
// GTP-U frame also scans up to N table entries (N is the fill count, up to 1024)
// and updates its counters: the TEID search reads each entry from memory, then compares it.
// Reset clears the table through a fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module gtpu_teid_telemetry_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream: tdata = frame_byte[7:0]; tlast = frame_last.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,
    // Result stream, tdata from bit 0 up: pkt_class[1:0], tunnel_id[33:2],
    // frame_length[48:34], gtp_msg_type[56:49], outer_src_addr[88:57],
    // outer_dst_addr[120:89], udp_src_port[136:121], udp_dst_port[152:137],
    // tunnel_pkts[216:153], tunnel_bytes[280:217], table_full[281],
    // global_stat[345:282], zero fill up to bit 351.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gtpu_tp_pkg::OUT_W-1:0]       m_tdata,
    // Configuration: index 0 tunnel UDP port, index 1 stat_select.
    input  logic                                cfg_we,
    input  logic [gtpu_tp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gtpu_tp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gtpu_tp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller walks the frame-end sequence; the datapath owns all
    // captured fields, the table memories and the counters.
    gtpu_tp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gtpu_tp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

    // A pending result blocks intake of the next frame's bytes.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input accepted while a result is pending");

    // Tunnel fields are zero unless the frame was counted as GTP-U.
    a_non_gtpu_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != CLS_GTPU) |->
        (m_tdata[33:2] == '0 && m_tdata[281] == 1'b0 && m_tdata[216:153] == '0))
        else $error("tunnel fields set on a frame that is not GTP-U");

    // A full-table miss reports no tunnel counts.
    a_full_no_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[281]) |->
        (m_tdata[216:153] == '0 && m_tdata[280:217] == '0))
        else $error("counts reported for a TEID that was not inserted");

    // Only an accepted final byte starts a frame-end sequence.
    a_cmd_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.classify |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("classification without a final byte");

endmodule

// ----- rtl/gtpu_tp_ctrl.sv -----
// ----------------------------------------------------------------------------
// GTP-U telemetry parser controller
// Sequences byte intake, classification, table search, update and output.
// ----------------------------------------------------------------------------
module gtpu_tp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  gtpu_tp_pkg::stat_t stat,
    output gtpu_tp_pkg::cmd_t  cmd
);
    import gtpu_tp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (!stat.gtpu)
                begin
                    state_next = ST_LOAD;
                end
                else if (stat.empty)
                begin
                    state_next = ST_CNT_WR;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    state_next = ST_CNT_RD;
                end
                else if (stat.scan_last)
                begin
                    state_next = stat.full ? ST_LOAD : ST_CNT_WR;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_tready      = (state_reg == ST_RECV);
        m_tvalid      = (state_reg == ST_OUT);
        cmd.byte_take = (state_reg == ST_RECV) && s_tvalid;
        cmd.classify  = (state_reg == ST_CLASSIFY);
        cmd.scan_rd   = (state_reg == ST_SCAN_RD);
        cmd.scan_cmp  = (state_reg == ST_SCAN_CMP);
        cmd.cnt_rd    = (state_reg == ST_CNT_RD);
        cmd.cnt_wr    = (state_reg == ST_CNT_WR);
        cmd.load      = (state_reg == ST_LOAD);
    end

endmodule

// ----- rtl/gtpu_tp_dpath.sv -----
// ----------------------------------------------------------------------------
// GTP-U telemetry parser datapath
// Header capture, classification, TEID table memories and counters.
// ----------------------------------------------------------------------------
module gtpu_tp_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [7:0]                             s_tdata,
    input  logic                                   cfg_we,
    input  logic [gtpu_tp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gtpu_tp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gtpu_tp_pkg::cmd_t                      cmd,
    output gtpu_tp_pkg::stat_t                     stat,
    output logic [gtpu_tp_pkg::OUT_W-1:0]          m_tdata
);
    import gtpu_tp_pkg::*;

    logic [15:0]        tunnel_port_reg;
    logic [1:0]         stat_select_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [15:0]        ethertype_reg;
    logic [7:0]         verihl_reg;
    logic [7:0]         proto_reg;
    logic [3:0]         ihl_reg;
    logic [31:0]        src_reg;
    logic [31:0]        dst_reg;
    logic [15:0]        sport_reg;
    logic [15:0]        dport_reg;
    logic [7:0]         msg_reg;
    logic [31:0]        teid_reg;

    logic [1:0]         cls_reg;
    logic [63:0]        gcnt_reg [4];
    logic [TIDX_W-1:0]  scan_idx_reg;
    logic [TIDX_W-1:0]  hit_idx_reg;
    logic               hit_reg;
    logic               full_flag_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [31:0]        tid_rd_reg;
    logic [63:0]        pkt_rd_reg;
    logic [63:0]        byte_rd_reg;
    logic [63:0]        tun_pkts_reg;
    logic [63:0]        tun_bytes_reg;
    logic [OUT_W-1:0]   out_reg;

    logic [31:0]        tid_mem  [TABLE_ENTRIES];
    logic [63:0]        pkt_mem  [TABLE_ENTRIES];
    logic [63:0]        byte_mem [TABLE_ENTRIES];

    logic [POS_W-1:0]   udp_base;
    logic [POS_W-1:0]   udp_off;
    logic               past_base;
    logic [POS_W-1:0]   udp_end;
    logic [1:0]         cls_c;
    logic [63:0]        len64;
    logic [63:0]        pkt_new;
    logic [63:0]        byte_new;
    logic               gtpu_out;

    // IPv4 header ends (and UDP begins) at 14 + 4 * IHL.
    assign udp_base  = POS_W'(14) + {{(POS_W-6){1'b0}}, ihl_reg, 2'b00};
    assign past_base = (pos_reg >= POS_W'(15)) && (pos_reg >= udp_base);
    assign udp_off   = pos_reg - udp_base;
    assign udp_end   = POS_W'(22) + {{(POS_W-6){1'b0}}, verihl_reg[3:0], 2'b00};
    assign len64     = {{(64-POS_W){1'b0}}, pos_reg};

    always_comb
    begin
        if (pos_reg < POS_W'(14))
        begin
            cls_c = CLS_RUNT;
        end
        else if (ethertype_reg != ETHERTYPE_IPV4)
        begin
            cls_c = CLS_NON_GTPU;
        end
        else if (pos_reg < POS_W'(34))
        begin
            cls_c = CLS_MALFORMED;
        end
        else if (verihl_reg[7:4] != 4'd4 || verihl_reg[3:0] < 4'd5)
        begin
            cls_c = CLS_MALFORMED;
        end
        else if (proto_reg != PROTO_UDP)
        begin
            cls_c = CLS_NON_GTPU;
        end
        else if (pos_reg < udp_end)
        begin
            cls_c = CLS_MALFORMED;
        end
        else if (sport_reg != tunnel_port_reg && dport_reg != tunnel_port_reg)
        begin
            cls_c = CLS_NON_GTPU;
        end
        else if (pos_reg < udp_end + POS_W'(8))
        begin
            cls_c = CLS_MALFORMED;
        end
        else
        begin
            cls_c = CLS_GTPU;
        end
    end

    always_comb
    begin
        stat.gtpu      = (cls_c == CLS_GTPU);
        stat.empty     = (fill_reg == '0);
        stat.match     = (tid_rd_reg == teid_reg);
        stat.scan_last = ({1'b0, scan_idx_reg} == fill_reg - FILL_W'(1));
        stat.full      = (fill_reg == FILL_W'(TABLE_ENTRIES));
    end

    assign pkt_new  = hit_reg ? pkt_rd_reg + 64'd1 : 64'd1;
    assign byte_new = hit_reg ? byte_rd_reg + len64 : len64;
    assign gtpu_out = (cls_reg == CLS_GTPU);
    assign m_tdata  = out_reg;

    // Configuration and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tunnel_port_reg <= 16'd2152;
            stat_select_reg <= 2'd0;
            pos_reg         <= '0;
            ihl_reg         <= '0;
            fill_reg        <= '0;
            for (int i = 0; i < 4; i++)
            begin
                gcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == REG_TUNNEL_PORT)
            begin
                tunnel_port_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_STAT_SELECT)
            begin
                stat_select_reg <= cfg_data[1:0];
            end
            if (cmd.byte_take && pos_reg < POS_W'(MAX_FRAME_BYTES))
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(14))
                begin
                    ihl_reg <= s_tdata[3:0];
                end
            end
            if (cmd.classify)
            begin
                case (cls_c)
                    CLS_GTPU:
                    begin
                        gcnt_reg[0] <= gcnt_reg[0] + 64'd1;
                        gcnt_reg[1] <= gcnt_reg[1] + len64;
                    end
                    CLS_MALFORMED: gcnt_reg[2] <= gcnt_reg[2] + 64'd1;
                    CLS_NON_GTPU:  gcnt_reg[3] <= gcnt_reg[3] + 64'd1;
                    default:       ;
                endcase
            end
            if (cmd.cnt_wr && !hit_reg)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.load)
            begin
                pos_reg <= '0;
                ihl_reg <= '0;
            end
        end
    end

    // Header capture and per-frame payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.byte_take && pos_reg < POS_W'(MAX_FRAME_BYTES))
        begin
            case (pos_reg)
                POS_W'(12): ethertype_reg[15:8] <= s_tdata;
                POS_W'(13): ethertype_reg[7:0]  <= s_tdata;
                POS_W'(14): verihl_reg          <= s_tdata;
                POS_W'(23): proto_reg           <= s_tdata;
                POS_W'(26): src_reg[31:24]      <= s_tdata;
                POS_W'(27): src_reg[23:16]      <= s_tdata;
                POS_W'(28): src_reg[15:8]       <= s_tdata;
                POS_W'(29): src_reg[7:0]        <= s_tdata;
                POS_W'(30): dst_reg[31:24]      <= s_tdata;
                POS_W'(31): dst_reg[23:16]      <= s_tdata;
                POS_W'(32): dst_reg[15:8]       <= s_tdata;
                POS_W'(33): dst_reg[7:0]        <= s_tdata;
                default:    ;
            endcase
            if (past_base)
            begin
                case (udp_off)
                    POS_W'(0):  sport_reg[15:8]  <= s_tdata;
                    POS_W'(1):  sport_reg[7:0]   <= s_tdata;
                    POS_W'(2):  dport_reg[15:8]  <= s_tdata;
                    POS_W'(3):  dport_reg[7:0]   <= s_tdata;
                    POS_W'(9):  msg_reg          <= s_tdata;
                    POS_W'(12): teid_reg[31:24]  <= s_tdata;
                    POS_W'(13): teid_reg[23:16]  <= s_tdata;
                    POS_W'(14): teid_reg[15:8]   <= s_tdata;
                    POS_W'(15): teid_reg[7:0]    <= s_tdata;
                    default:    ;
                endcase
            end
        end
        if (cmd.load)
        begin
            ethertype_reg <= '0;
            verihl_reg    <= '0;
            proto_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
            msg_reg       <= '0;
            teid_reg      <= '0;
        end

        if (cmd.classify)
        begin
            cls_reg       <= cls_c;
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            full_flag_reg <= 1'b0;
            hit_idx_reg   <= fill_reg[TIDX_W-1:0];
            tun_pkts_reg  <= '0;
            tun_bytes_reg <= '0;
        end
        if (cmd.scan_cmp)
        begin
            if (stat.match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= scan_idx_reg;
            end
            else if (stat.scan_last)
            begin
                full_flag_reg <= stat.full;
            end
            else
            begin
                scan_idx_reg <= scan_idx_reg + TIDX_W'(1);
            end
        end
        if (cmd.cnt_wr)
        begin
            tun_pkts_reg  <= pkt_new;
            tun_bytes_reg <= byte_new;
        end
        if (cmd.load)
        begin
            out_reg <= {6'd0,
                        gcnt_reg[stat_select_reg],
                        full_flag_reg,
                        tun_bytes_reg,
                        tun_pkts_reg,
                        gtpu_out ? dport_reg : 16'd0,
                        gtpu_out ? sport_reg : 16'd0,
                        gtpu_out ? dst_reg : 32'd0,
                        gtpu_out ? src_reg : 32'd0,
                        gtpu_out ? msg_reg : 8'd0,
                        pos_reg,
                        gtpu_out ? teid_reg : 32'd0,
                        cls_reg};
        end
    end

    // TEID table memories.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            tid_rd_reg <= tid_mem[scan_idx_reg];
        end
        if (cmd.cnt_rd)
        begin
            pkt_rd_reg  <= pkt_mem[hit_idx_reg];
            byte_rd_reg <= byte_mem[hit_idx_reg];
        end
        if (cmd.cnt_wr)
        begin
            pkt_mem[hit_idx_reg]  <= pkt_new;
            byte_mem[hit_idx_reg] <= byte_new;
            if (!hit_reg)
            begin
                tid_mem[hit_idx_reg] <= teid_reg;
            end
        end
    end

endmodule
